### rtl/spc_pkg.sv
package spc_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxCols    = 512;
  localparam int SampleBits = 16;

  // Fixed field widths.
  localparam int RowLenW  = 10;
  localparam int RowCntW  = 16;
  localparam int ThreshW  = 5;
  localparam int RowOutW  = 16;
  localparam int ColOutW  = 9;
  localparam int ValueW   = 16;
  localparam int LaneCntW = 4;
  localparam int SumW     = 5;

  // Register map of the configuration port.
  localparam int PaddrW = 4;
  localparam int PdataW = 32;
  localparam logic [PaddrW-1:0] AddrRowLength     = 4'h0;
  localparam logic [PaddrW-1:0] AddrRowCount      = 4'h4;
  localparam logic [PaddrW-1:0] AddrCountThreshold = 4'h8;

  localparam logic [RowLenW-1:0] RowLengthReset      = 10'd360;
  localparam logic [RowCntW-1:0] RowCountReset       = 16'd120;
  localparam logic [ThreshW-1:0] CountThresholdReset = 5'd9;

  // What one frame lane finds in its 3x3 window.
  typedef struct packed {
    logic [LaneCntW-1:0] cnt;
    logic                ctr;
  } lane_t;

  // One result word.
  typedef struct packed {
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic               core;
    logic [ValueW-1:0]  value;
  } res_t;

endpackage

### rtl/spatiotemporal_core_point_stencil_core.sv
// Spatiotemporal core-point stencil.
// The input channel carries one word per raster position: the samples of the
// previous, current and next frame at that position, in raster order. For
// every interior pixel (one row up and one column left of the newest position,
// once row and column are both at least two) one output word is given: its
// row and column, whether its 3x3x3 neighborhood holds at least
// count_threshold nonzero samples (the count is zero when any frame's center
// is empty), and the raw current-frame value. Border pixels give no word.
// Throughput is one input word per cycle while the skid register is empty.
// From acceptance a word passes the line-store read, the window shift and the
// lane counts, whose merge feeds the output register. The column line stores
// are single memories with one write and one registered read port per cycle.
// The output side has a result register and a skid register. When the
// receiver stalls, the pipeline keeps accepting until the skid register
// fills; in_stall_o is the registered skid-full flag.
// Reset clears the position counters, the 3x3x3 flag window, the held center
// value and all valid bits, and loads the register defaults (row_length 360,
// row_count 120, count_threshold 9). The line stores are not cleared; the
// first two rows of a frame only fill them. Configuration is written over
// the APB port while no word is in flight.
module spatiotemporal_core_point_stencil_core #(
  parameter int MaxCols    = spc_pkg::MaxCols,
  parameter int SampleBits = spc_pkg::SampleBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spc_pkg::PaddrW-1:0]         paddr,
  input  logic [spc_pkg::PdataW-1:0]         pwdata,
  output logic [spc_pkg::PdataW-1:0]         prdata,
  output logic                               pready,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SampleBits-1:0]       sample_prev_i,
  input  logic signed [SampleBits-1:0]       sample_cur_i,
  input  logic signed [SampleBits-1:0]       sample_next_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [spc_pkg::RowOutW-1:0]        center_row_o,
  output logic [spc_pkg::ColOutW-1:0]        center_col_o,
  output logic                               is_core_o,
  output logic signed [spc_pkg::ValueW-1:0]  center_value_o
);

  localparam int ColW = $clog2(MaxCols);
  localparam int CmpW = (ColW + 1 > spc_pkg::RowLenW) ? ColW + 1 : spc_pkg::RowLenW;
  localparam int RcW  = spc_pkg::RowCntW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [spc_pkg::RowLenW-1:0] row_length_q;
  logic [spc_pkg::RowCntW-1:0] row_count_q;
  logic [spc_pkg::ThreshW-1:0] threshold_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= spc_pkg::RowLengthReset;
      row_count_q  <= spc_pkg::RowCountReset;
      threshold_q  <= spc_pkg::CountThresholdReset;
    end else if (cfg_wr) begin
      case (paddr)
        spc_pkg::AddrRowLength:      row_length_q <= pwdata[spc_pkg::RowLenW-1:0];
        spc_pkg::AddrRowCount:       row_count_q  <= pwdata[spc_pkg::RowCntW-1:0];
        spc_pkg::AddrCountThreshold: threshold_q  <= pwdata[spc_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      spc_pkg::AddrRowLength:      prdata = spc_pkg::PdataW'(row_length_q);
      spc_pkg::AddrRowCount:       prdata = spc_pkg::PdataW'(row_count_q);
      spc_pkg::AddrCountThreshold: prdata = spc_pkg::PdataW'(threshold_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage moves while the skid register is empty.
  // ---------------------------------------------------------------------------
  logic skid_valid_q;
  logic out_valid_q;
  logic en;
  logic accept;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && en;

  // ---------------------------------------------------------------------------
  // Raster position. Out-of-range lengths are clamped to the legal range.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]            col_q;
  logic [spc_pkg::RowCntW-1:0] row_q;
  logic [CmpW-1:0]            rl_ext;
  logic [CmpW-1:0]            rl_eff;
  logic [RcW-1:0]             rc_eff;
  logic [CmpW-1:0]            col_inc;
  logic [RcW-1:0]             row_inc;

  always_comb begin
    rl_ext = CmpW'(row_length_q);
    if (rl_ext < CmpW'(3)) begin
      rl_eff = CmpW'(3);
    end else if (rl_ext > CmpW'(MaxCols)) begin
      rl_eff = CmpW'(MaxCols);
    end else begin
      rl_eff = rl_ext;
    end
    if (row_count_q < spc_pkg::RowCntW'(3)) begin
      rc_eff = RcW'(3);
    end else begin
      rc_eff = RcW'(row_count_q);
    end
    col_inc = CmpW'(col_q) + CmpW'(1);
    row_inc = RcW'(row_q) + RcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_inc >= rl_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= rc_eff) ? '0 : row_inc[spc_pkg::RowCntW-1:0];
      end else begin
        col_q <= col_inc[ColW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the word is registered while the line stores are read at its
  // column. The flag store keeps the rows one and two above in one entry.
  // ---------------------------------------------------------------------------
  logic                        s1_valid_q;
  logic [2:0]                  s1_nf_q;
  logic [SampleBits-1:0]       s1_sc_q;
  logic [ColW-1:0]             s1_col_q;
  logic [spc_pkg::RowCntW-1:0] s1_row_q;
  logic [5:0]                  flag_rdata;
  logic [SampleBits-1:0]       value_rdata;
  logic                        line_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_nf_q  <= {|sample_next_i, |sample_cur_i, |sample_prev_i};
      s1_sc_q  <= sample_cur_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  assign line_we = en && s1_valid_q;

  spc_ram #(
    .Width (6),
    .Depth (MaxCols)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_col_q),
    .wdata_i ({flag_rdata[2:0], s1_nf_q}),
    .re_i    (en),
    .raddr_i (col_q),
    .rdata_o (flag_rdata)
  );

  spc_ram #(
    .Width (SampleBits),
    .Depth (MaxCols)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_col_q),
    .wdata_i (s1_sc_q),
    .re_i    (en),
    .raddr_i (col_q),
    .rdata_o (value_rdata)
  );

  // New window column: per frame f, bit 3f is two rows up, 3f+1 one row up
  // and 3f+2 the current row.
  logic [8:0] col_bits;

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      col_bits[3*f]     = flag_rdata[3+f];
      col_bits[3*f + 1] = flag_rdata[f];
      col_bits[3*f + 2] = s1_nf_q[f];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the 3x3x3 window and the held center value advance per word.
  // ---------------------------------------------------------------------------
  logic [26:0]                 window_q;
  logic [SampleBits-1:0]       hold_q;
  logic                        s2_valid_q;
  logic [spc_pkg::RowOutW-1:0] s2_row_q;
  logic [spc_pkg::ColOutW-1:0] s2_col_q;
  logic [spc_pkg::ValueW-1:0]  s2_value_q;
  logic                        interior;

  assign interior = (s1_row_q >= spc_pkg::RowCntW'(2)) && (s1_col_q >= ColW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      hold_q     <= '0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && interior;
      if (s1_valid_q) begin
        window_q <= {window_q[17:0], col_bits};
        hold_q   <= value_rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      s2_row_q   <= s1_row_q - spc_pkg::RowCntW'(1);
      s2_col_q   <= spc_pkg::ColOutW'(32'(s1_col_q) - 32'd1);
      // The held value belongs to the pixel one column left of this word.
      s2_value_q <= spc_pkg::ValueW'(hold_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: one lane per frame counts its 3x3 plane.
  // ---------------------------------------------------------------------------
  spc_pkg::lane_t [2:0]        lane_res;
  spc_pkg::lane_t [2:0]        s3_lane_q;
  logic                        s3_valid_q;
  spc_pkg::res_t               s3_res_q;

  for (genvar f = 0; f < 3; f++) begin : g_lane
    spc_lane u_lane (
      .flags_i ({window_q[3*f+20:3*f+18], window_q[3*f+11:3*f+9], window_q[3*f+2:3*f]}),
      .lane_o  (lane_res[f])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q) begin
      s3_lane_q      <= lane_res;
      s3_res_q.row   <= s2_row_q;
      s3_res_q.col   <= s2_col_q;
      s3_res_q.core  <= 1'b0;
      s3_res_q.value <= s2_value_q;
    end
  end

  // Merge of the lanes feeds the output register directly.
  logic          merged_core;
  spc_pkg::res_t pipe_res;
  logic          pipe_valid;

  spc_merge u_merge (
    .lanes_i     (s3_lane_q),
    .threshold_i (threshold_q),
    .core_o      (merged_core)
  );

  always_comb begin
    pipe_res      = s3_res_q;
    pipe_res.core = merged_core;
  end

  assign pipe_valid = en && s3_valid_q;

  // ---------------------------------------------------------------------------
  // Output register and skid register.
  // ---------------------------------------------------------------------------
  spc_pkg::res_t out_q;
  spc_pkg::res_t skid_q;
  logic          take;

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pipe_valid) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_valid) begin
      if (!out_valid_q || take) begin
        out_q <= pipe_res;
      end else begin
        skid_q <= pipe_res;
      end
    end else if (take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign center_row_o   = out_q.row;
  assign center_col_o   = out_q.col;
  assign is_core_o      = out_q.core;
  assign center_value_o = out_q.value;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The skid register only holds a word behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // The skid register only fills while the receiver stalls a waiting word.
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid register filled without a stall");

  // An empty center in any frame makes the pixel core only at threshold zero.
  a_core_needs_centers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_valid && !(s3_lane_q[0].ctr && s3_lane_q[1].ctr && s3_lane_q[2].ctr)
     && (threshold_q != '0)) |-> !merged_core)
    else $error("core pixel with an empty center");

  // Judged pixels are interior, so their row and column are never zero.
  a_interior_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_valid |-> (pipe_res.row != '0) && (pipe_res.col != '0))
    else $error("border pixel reached the output");

endmodule

### rtl/spc_ram.sv
module spc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spc_lane.sv
// Counts the set flags of one frame's 3x3 window and reports its center flag.
// Flag order: oldest column in [8:6], middle column in [5:3], newest in [2:0];
// within a column the row above-above is bit 0 and the current row is bit 2.
module spc_lane (
  input  logic [8:0]          flags_i,
  output spc_pkg::lane_t      lane_o
);

  logic [spc_pkg::LaneCntW-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 9; k++) begin
      cnt = cnt + spc_pkg::LaneCntW'(flags_i[k]);
    end
  end

  assign lane_o.cnt = cnt;
  assign lane_o.ctr = flags_i[4];

endmodule

### rtl/spc_merge.sv
// Combines the three frame lanes: the count only stands when every frame's
// center is set, and the pixel is core when the count reaches the threshold.
module spc_merge (
  input  spc_pkg::lane_t [2:0]         lanes_i,
  input  logic [spc_pkg::ThreshW-1:0]  threshold_i,
  output logic                         core_o
);

  logic                       all_ctr;
  logic [spc_pkg::SumW-1:0]   sum;

  always_comb begin
    all_ctr = lanes_i[0].ctr & lanes_i[1].ctr & lanes_i[2].ctr;
    sum     = '0;
    if (all_ctr) begin
      sum = spc_pkg::SumW'(lanes_i[0].cnt) + spc_pkg::SumW'(lanes_i[1].cnt)
          + spc_pkg::SumW'(lanes_i[2].cnt);
    end
  end

  assign core_o = (sum >= threshold_i);

endmodule

### verif/spatiotemporal_core_point_stencil_core_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the spatiotemporal core-point stencil.
//
// Every pixel word handed to the driver is first run through a bench-side
// model of the stencil (line stores, 3x3x3 flag window, held center value and
// raster position). The model keeps its own copy of the configuration. Each
// interior pixel it judges lands in a queue of judged words. The monitor pops
// the oldest judged word for every word accepted on the output channel and
// compares it field by field.
//
// Configuration changes go over the APB port only once the block has
// drained: no pixel word pending, every judged word delivered and a drain
// wait for border pixels still in the pipeline.
module spatiotemporal_core_point_stencil_core_test;

  localparam int Cols        = spc_pkg::MaxCols;
  localparam int DrainCycles = 8;    // three pipeline stages plus the skid register
  localparam int LongHold    = 120;  // receiver hold-off that backs the block up
  localparam int RandomItems = 340;
  localparam int HoldItems   = 80;   // words offered during the long hold-off

  // One input word: the three frame samples at one raster position.
  typedef struct packed {
    logic [spc_pkg::SampleBits-1:0] prev;
    logic [spc_pkg::SampleBits-1:0] cur;
    logic [spc_pkg::SampleBits-1:0] nxt;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [spc_pkg::PaddrW-1:0] paddr   = '0;
  logic [spc_pkg::PdataW-1:0] pwdata  = '0;
  logic [spc_pkg::PdataW-1:0] prdata;
  logic                       pready;

  logic                                  in_valid      = 1'b0;
  logic                                  in_stall_o;
  logic signed [spc_pkg::SampleBits-1:0] sample_prev   = '0;
  logic signed [spc_pkg::SampleBits-1:0] sample_cur    = '0;
  logic signed [spc_pkg::SampleBits-1:0] sample_next   = '0;

  logic                              out_valid_o;
  logic                              out_stall     = 1'b0;
  logic [spc_pkg::RowOutW-1:0]       center_row_o;
  logic [spc_pkg::ColOutW-1:0]       center_col_o;
  logic                              is_core_o;
  logic signed [spc_pkg::ValueW-1:0] center_value_o;

  spatiotemporal_core_point_stencil_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .sample_prev_i  (sample_prev),
    .sample_cur_i   (sample_cur),
    .sample_next_i  (sample_next),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .center_row_o   (center_row_o),
    .center_col_o   (center_col_o),
    .is_core_o      (is_core_o),
    .center_value_o (center_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting for the driver, and judged words waiting for the monitor.
  pixel_t        pixel_q[$];
  spc_pkg::res_t judged_q[$];

  int unsigned mismatch_count = 0;

  // Idle bursts are on for most phases; the closing phase runs without them.
  bit idle_on = 1'b1;

  // The generator bumps hold_req to ask the receiver for one long hold-off.
  int unsigned hold_req = 0;

  // ---------------------------------------------------------------------------
  // Bench-side stencil model
  // ---------------------------------------------------------------------------
  logic [spc_pkg::RowLenW-1:0] row_length_q;
  logic [spc_pkg::RowCntW-1:0] row_count_q;
  logic [spc_pkg::ThreshW-1:0] threshold_q;

  logic [2:0]                 flags_up1 [Cols];  // nonzero flags of the row above
  logic [2:0]                 flags_up2 [Cols];  // nonzero flags two rows above
  logic [spc_pkg::ValueW-1:0] value_up  [Cols];  // current-frame values of the row above
  logic [1:0]                 col_visits[Cols];  // saturating count of visits since reset
  logic [26:0]                window;
  logic [spc_pkg::ValueW-1:0] center_hold;
  int unsigned                row_pos;
  int unsigned                col_pos;

  function automatic int unsigned eff_length(input int unsigned len);
    if (len < 3) return 3;
    if (len > Cols) return Cols;
    return len;
  endfunction

  function automatic int unsigned eff_rows(input int unsigned rows);
    return (rows < 3) ? 3 : rows;
  endfunction

  // Takes one pixel word, updates the model state and queues the judged word
  // when the position closes a full 3x3 neighborhood.
  function automatic void judge_pixel(input pixel_t px);
    logic [2:0]    nz;
    logic [2:0]    up1;
    logic [2:0]    up2;
    logic [8:0]    column;
    int unsigned   rl;
    int unsigned   rc;
    int unsigned   c;
    int unsigned   r;
    int unsigned   cnt;
    int            f;
    spc_pkg::res_t res;

    rl = eff_length(row_length_q);
    rc = eff_rows(row_count_q);
    c  = col_pos;
    r  = row_pos;

    nz  = {px.nxt != '0, px.cur != '0, px.prev != '0};
    up1 = flags_up1[c];
    up2 = flags_up2[c];
    flags_up2[c] = up1;
    flags_up1[c] = nz;
    if (col_visits[c] != 2'd2) col_visits[c] = col_visits[c] + 2'd1;

    // Each frame contributes its column oldest row first.
    for (f = 0; f < 3; f++) begin
      column[3*f]     = up2[f];
      column[3*f + 1] = up1[f];
      column[3*f + 2] = nz[f];
    end
    window = {window[17:0], column};

    res.value   = center_hold;
    center_hold = value_up[c];
    value_up[c] = px.cur;

    if (r >= 2 && c >= 2) begin
      cnt = 0;
      // An empty center in any frame forces the count to zero.
      if (window[10] && window[13] && window[16]) cnt = $countones(window);
      res.row  = spc_pkg::RowOutW'(r - 1);
      res.col  = spc_pkg::ColOutW'(c - 1);
      res.core = (cnt >= threshold_q);
      judged_q = {judged_q, res};
    end

    if (c + 1 >= rl) begin
      col_pos = 0;
      row_pos = (r + 1 >= rc) ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void set_register(input logic [spc_pkg::PaddrW-1:0] addr,
                                       input logic [spc_pkg::PdataW-1:0] data);
    case (addr)
      spc_pkg::AddrRowLength:      row_length_q = data[spc_pkg::RowLenW-1:0];
      spc_pkg::AddrRowCount:       row_count_q  = data[spc_pkg::RowCntW-1:0];
      spc_pkg::AddrCountThreshold: threshold_q  = data[spc_pkg::ThreshW-1:0];
      default: ;
    endcase
  endfunction

  // Growing the row mid-frame must not reach columns whose line entries were
  // never written; at the start of a frame the first two rows only fill them.
  function automatic bit row_growth_safe(input int unsigned len);
    int unsigned c;
    if (row_pos == 0 && col_pos == 0) return 1'b1;
    for (c = 0; c < eff_length(len); c++) begin
      if (col_visits[c] != 2'd2) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one pixel word per handshake, with random gaps between words.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || !in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        sample_prev <= pixel_q[0].prev;
        sample_cur  <= pixel_q[0].cur;
        sample_next <= pixel_q[0].nxt;
        in_valid    <= 1'b1;
        void'(pixel_q.pop_front());
        if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, plus one long hold-off on request. During
  // the long hold-off the driver keeps offering words, so the pipeline and the
  // skid register fill and the block raises in_stall_o.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LongHold - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result word is checked against the oldest judged
  // word.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  spc_pkg::res_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (judged_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word row %0d col %0d",
                                  center_row_o, center_col_o));
      end else begin
        want = judged_q.pop_front();
        if (center_row_o !== want.row)
          report_mismatch($sformatf("center_row %0d, want %0d", center_row_o, want.row));
        if (center_col_o !== want.col)
          report_mismatch($sformatf("center_col %0d, want %0d at row %0d",
                                    center_col_o, want.col, want.row));
        if (is_core_o !== want.core)
          report_mismatch($sformatf("is_core %0b, want %0b at row %0d col %0d",
                                    is_core_o, want.core, want.row, want.col));
        if (center_value_o !== want.value)
          report_mismatch($sformatf("center_value %h, want %h at row %0d col %0d",
                                    center_value_o, want.value, want.row, want.col));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [spc_pkg::SampleBits-1:0] pick_sample(input int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void send_pixel(input logic [spc_pkg::SampleBits-1:0] prev,
                                     input logic [spc_pkg::SampleBits-1:0] cur,
                                     input logic [spc_pkg::SampleBits-1:0] nxt);
    pixel_t px;
    px.prev = prev;
    px.cur  = cur;
    px.nxt  = nxt;
    judge_pixel(px);
    pixel_q = {pixel_q, px};
  endfunction

  function automatic void send_random(input int unsigned n, input int zero_pct);
    int unsigned i;
    for (i = 0; i < n; i++)
      send_pixel(pick_sample(zero_pct), pick_sample(zero_pct), pick_sample(zero_pct));
  endfunction

  // Waits until the block is drained: nothing left to send, the last word
  // accepted, every judged word delivered, then a drain wait for border
  // pixels that are still in the pipeline.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || judged_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [spc_pkg::PaddrW-1:0] addr,
                                input logic [spc_pkg::PdataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_register(addr, data);
  endtask

  // Runs the raster on to the start of the next frame. A tall frame is cut
  // short first by lowering row_count, so that the current row is its last.
  task automatic finish_frame(input int zero_pct);
    if (row_pos == 0 && col_pos == 0) return;
    if (eff_rows(row_count_q) - row_pos > 8) begin
      wait_idle();
      write_register(spc_pkg::AddrRowCount, spc_pkg::PdataW'(row_pos + 1));
    end
    while (row_pos != 0 || col_pos != 0) send_random(1, zero_pct);
  endtask

  // Writes the selected registers once the block is idle. Upper bits of the
  // write data are sometimes filled with noise, which the block must drop.
  task automatic configure(input int unsigned rl, input int unsigned rc,
                           input int unsigned th, input bit [2:0] which,
                           input int zero_pct);
    logic [spc_pkg::PdataW-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? spc_pkg::PdataW'($urandom) : '0;
    if (which[0] && !row_growth_safe(rl)) finish_frame(zero_pct);
    wait_idle();
    if (which[0])
      write_register(spc_pkg::AddrRowLength,
                     {junk[spc_pkg::PdataW-1:spc_pkg::RowLenW], rl[spc_pkg::RowLenW-1:0]});
    if (which[1])
      write_register(spc_pkg::AddrRowCount,
                     {junk[spc_pkg::PdataW-1:spc_pkg::RowCntW], rc[spc_pkg::RowCntW-1:0]});
    if (which[2])
      write_register(spc_pkg::AddrCountThreshold,
                     {junk[spc_pkg::PdataW-1:spc_pkg::ThreshW], th[spc_pkg::ThreshW-1:0]});
  endtask

  logic [spc_pkg::SampleBits-1:0] extremes [9];
  int unsigned                    rl_pick;
  int unsigned                    rc_pick;
  int unsigned                    th_pick;
  int unsigned                    n;
  int unsigned                    random_sent;
  int unsigned                    phase;
  int                             zero_pct;
  int                             i;

  initial begin
    row_length_q = spc_pkg::RowLengthReset;
    row_count_q  = spc_pkg::RowCountReset;
    threshold_q  = spc_pkg::CountThresholdReset;
    for (i = 0; i < Cols; i++) begin
      flags_up1[i]  = '0;
      flags_up2[i]  = '0;
      value_up[i]   = '0;
      col_visits[i] = '0;
    end
    window      = '0;
    center_hold = '0;
    row_pos     = 0;
    col_pos     = 0;

    extremes[0] = 16'h8000;
    extremes[1] = 16'h7FFF;
    extremes[2] = 16'h0000;
    extremes[3] = 16'hFFFF;
    extremes[4] = 16'h0001;
    extremes[5] = 16'h5555;
    extremes[6] = 16'hAAAA;
    extremes[7] = 16'h0000;
    extremes[8] = 16'h7FFE;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frames. Row length and row count of zero act as three; with a
    // threshold of zero the single interior pixel is core even though its
    // current-frame center is empty.
    configure(0, 0, 0, 3'b111, 0);
    for (i = 0; i < 9; i++)
      send_pixel(extremes[i], (i == 4) ? 16'h0000 : extremes[(i + 3) % 9],
                 extremes[(i + 6) % 9]);

    // Every sample nonzero: the count reaches 27, its top value, at threshold 27.
    configure(3, 3, 27, 3'b111, 0);
    for (i = 0; i < 9; i++)
      send_pixel((i % 2) ? 16'h8000 : 16'h0001, 16'h7FFF, (i % 3) ? 16'hFFFF : 16'h8001);

    // One empty center in the next frame zeroes the count even at threshold one.
    configure(3, 3, 1, 3'b100, 0);
    for (i = 0; i < 9; i++)
      send_pixel(16'hFFFF, 16'h8000, (i == 4) ? 16'h0000 : 16'h7FFF);

    // Tallest frame, then changes in the middle of a frame: the row count
    // drops below the current row, so the raster wraps after this row; later
    // the row length drops below the current column, so the column wraps.
    configure(3, 65535, 5, 3'b111, 30);
    send_random(30, 30);
    configure(3, 4, 5, 3'b010, 30);
    send_random(10, 30);
    configure(8, 4, 12, 3'b101, 30);
    send_random(14, 30);
    configure(5, 4, 12, 3'b001, 30);
    send_random(24, 30);

    // Random phases, mostly small frames. The third one is run under a long
    // receiver hold-off.
    random_sent = 0;
    phase = 0;
    while (random_sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       rl_pick = $urandom_range(0, 2);
        1:       rl_pick = $urandom_range(13, 64);
        2:       rl_pick = $urandom_range(513, 1023);
        default: rl_pick = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       rc_pick = $urandom_range(0, 2);
        1:       rc_pick = $urandom_range(9, 65535);
        default: rc_pick = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       th_pick = 0;
        1:       th_pick = 27;
        2:       th_pick = $urandom_range(28, 31);
        default: th_pick = $urandom_range(0, 27);
      endcase
      if (phase == 2) begin
        rl_pick = 10;
        rc_pick = 8;
      end
      zero_pct = $urandom_range(0, 70);
      idle_on  = ($urandom_range(0, 3) != 0);
      configure(rl_pick, rc_pick, th_pick,
                3'(($urandom_range(1, 7)) | ((phase == 2) ? 3 : 0)), zero_pct);
      n = (phase == 2) ? HoldItems : $urandom_range(20, 80);
      if (phase == 2) hold_req++;
      send_random(n, zero_pct);
      random_sent += n;
      phase++;
    end

    // Closing phase without any idling on either side.
    configure(6, 5, 9, 3'b111, 30);
    idle_on = 1'b0;
    send_random(60, 30);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (judged_q.size() != 0)
      report_mismatch($sformatf("%0d judged words never arrived", judged_q.size()));
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
